// ----- rtl/tcw_pkg.sv -----
// Package for the text console cell writer.
// Holds the shared constants, codes, queue entry and cell types, and the digit table.
// Used by every module of the block; depends on nothing.
package tcw_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Cursor and address widths.
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;

    // Input field widths.
    localparam int OP_W   = 2;
    localparam int CODE_W = 8;
    localparam int NUM_W  = 32;

    // Digit buffer: ten four-bit digits.
    localparam int DIGITS = 10;
    localparam int DIG_W  = 4 * DIGITS;
    localparam int CNT_W  = 4;

    // Reset value of the attribute register.
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
    localparam logic [OP_W-1:0] OP_HEX  = 2'd1;
    localparam logic [OP_W-1:0] OP_DEC  = 2'd2;

    // Character codes with a special meaning.
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CODE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CODE_W-1:0] CHAR_X       = 8'h78;

    // Digit glyphs, first character in the top byte.
    localparam logic [8*16-1:0] HEX_DIGITS = "0123456789ABCDEF";

    // Queue depth between the front and the back.
    localparam int FIFO_DEPTH = 2;

    // One unit of work for the back: a character, or a left-aligned digit string.
    typedef struct packed {
        logic [OP_W-1:0]   kind;
        logic [CODE_W-1:0] code;
        logic [DIG_W-1:0]  digits;
        logic [CNT_W-1:0]  count;
    } t_entry;

    // One cell write.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [15:0]       word;
        logic              last;
    } t_cell;

    // Glyph of one digit value.
    function automatic logic [CODE_W-1:0] hex_char(input logic [3:0] d);
        logic [3:0] idx;
        idx = 4'd15 - d;
        return HEX_DIGITS[8*idx +: 8];
    endfunction

endpackage

// ----- rtl/tcw_fifo.sv -----
// Two-entry register queue between the front and the back of the cell writer.
// Depends on tcw_pkg for the entry type and depth.
module tcw_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcw_pkg::t_entry i_entry,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output tcw_pkg::t_entry o_entry
);

    localparam int PTR_W = $clog2(tcw_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(tcw_pkg::FIFO_DEPTH + 1);

    tcw_pkg::t_entry r_mem [tcw_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(tcw_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- rtl/tcw_front.sv -----
// Front of the cell writer: accepts input transactions and turns them into queue entries.
// Decimal numbers go through a bit-serial binary to BCD converter. Depends on tcw_pkg.
module tcw_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [tcw_pkg::OP_W-1:0]    i_op,
    input  logic [tcw_pkg::CODE_W-1:0]  i_code,
    input  logic [tcw_pkg::NUM_W-1:0]   i_number,
    output logic                        o_push,
    output tcw_pkg::t_entry             o_entry,
    input  logic                        i_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CONV = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    localparam int STEP_W = $clog2(tcw_pkg::NUM_W);

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [tcw_pkg::NUM_W-1:0]   r_bin;
    logic [tcw_pkg::DIG_W-1:0]   r_bcd;
    logic [tcw_pkg::DIG_W-1:0]   n_bcd;
    logic [STEP_W-1:0]           r_step;

    logic                        v_accept;
    logic [tcw_pkg::CNT_W-1:0]   v_ndig;
    logic [5:0]                  v_shift;

    assign o_ready  = (r_state == F_IDLE) && !i_full;
    assign v_accept = i_valid && o_ready;

    // One double-dabble step: correct each digit, then shift in the next bit.
    always_comb begin
        logic [tcw_pkg::DIG_W-1:0] v_adj;
        v_adj = r_bcd;
        for (int i = 0; i < tcw_pkg::DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                v_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end
        end
        n_bcd = {v_adj[tcw_pkg::DIG_W-2:0], r_bin[tcw_pkg::NUM_W-1]};
    end

    // Count of significant digits, at least one, and the shift that left-aligns them.
    always_comb begin
        v_ndig = 4'd1;
        for (int i = 0; i < tcw_pkg::DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                v_ndig = tcw_pkg::CNT_W'(i + 1);
            end
        end
        v_shift = {(4'(tcw_pkg::DIGITS) - v_ndig), 2'b00};
    end

    // Entry and push towards the queue.
    always_comb begin
        o_push  = 1'b0;
        o_entry = '0;
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (v_accept) begin
                    case (i_op)
                        tcw_pkg::OP_CHAR: begin
                            o_push       = 1'b1;
                            o_entry.kind = tcw_pkg::OP_CHAR;
                            o_entry.code = i_code;
                        end
                        tcw_pkg::OP_HEX: begin
                            o_push         = 1'b1;
                            o_entry.kind   = tcw_pkg::OP_HEX;
                            o_entry.digits = {i_number, 8'h00};
                            o_entry.count  = 4'd8;
                        end
                        tcw_pkg::OP_DEC: begin
                            n_state = F_CONV;
                        end
                        default: begin
                            n_state = F_IDLE;
                        end
                    endcase
                end
            end
            F_CONV: begin
                if (r_step == '1) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                o_entry.kind   = tcw_pkg::OP_DEC;
                o_entry.digits = r_bcd << v_shift;
                o_entry.count  = v_ndig;
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_CONV) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    // Converter datapath.
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE) begin
            r_bin <= i_number;
            r_bcd <= '0;
        end else if (r_state == F_CONV) begin
            r_bin <= {r_bin[tcw_pkg::NUM_W-2:0], 1'b0};
            r_bcd <= n_bcd;
        end
    end

endmodule

// ----- rtl/tcw_back.sv -----
// Back of the cell writer: takes queue entries, tracks the cursor and emits cell writes.
// Drives the registered output stage. Depends on tcw_pkg.
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_attr,
    input  logic            i_empty,
    input  tcw_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output tcw_pkg::t_cell  o_cell
);

    logic                          r_busy;
    logic [tcw_pkg::OP_W-1:0]      r_kind;
    logic [tcw_pkg::CODE_W-1:0]    r_code;
    logic [tcw_pkg::DIG_W-1:0]     r_digits;
    logic [tcw_pkg::CNT_W-1:0]     r_left;
    logic [1:0]                    r_pre;
    logic [tcw_pkg::COL_W-1:0]     r_col;
    logic [tcw_pkg::ROW_W-1:0]     r_row;
    logic                          r_o_valid;
    tcw_pkg::t_cell                r_o_cell;

    logic [tcw_pkg::COL_W-1:0]     n_col;
    logic [tcw_pkg::ROW_W-1:0]     n_row;
    logic [tcw_pkg::ROW_W-1:0]     v_row_inc;
    logic [tcw_pkg::CODE_W-1:0]    v_char;
    logic                          v_last;
    logic                          v_fire;
    logic                          v_newline;
    logic [11:0]                   v_addr;

    assign o_valid = r_o_valid;
    assign o_cell  = r_o_cell;

    // A cell goes out when the output register is free or being drained.
    assign v_fire    = r_busy && (!r_o_valid || i_ready);
    assign o_pop     = !r_busy && !i_empty;
    assign v_newline = (i_entry.kind == tcw_pkg::OP_CHAR) &&
                       (i_entry.code == tcw_pkg::NEWLINE_CODE);

    // Row advance with wrap past the last row.
    assign v_row_inc = (r_row == tcw_pkg::ROW_W'(ROWS - 1)) ? '0 : r_row + 1'b1;

    // Cursor after a cell write.
    always_comb begin
        if (r_col == tcw_pkg::COL_W'(COLUMNS - 1)) begin
            n_col = '0;
            n_row = v_row_inc;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    // Character of the current cell and whether it ends the item.
    always_comb begin
        v_char = tcw_pkg::hex_char(r_digits[tcw_pkg::DIG_W-1 -: 4]);
        v_last = (r_pre == 2'd0) && (r_left == 4'd1);
        if (r_kind == tcw_pkg::OP_CHAR) begin
            v_char = r_code;
            v_last = 1'b1;
        end else if (r_pre == 2'd2) begin
            v_char = tcw_pkg::CHAR_ZERO;
        end else if (r_pre == 2'd1) begin
            v_char = tcw_pkg::CHAR_X;
        end
    end

    assign v_addr = 12'(r_row) * 12'(COLUMNS) + 12'(r_col);

    // Sequencer and cursor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // The output register fills on a cell write and empties when taken.
            if (v_fire) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (o_pop) begin
                if (v_newline) begin
                    r_col <= '0;
                    r_row <= v_row_inc;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (v_fire) begin
                r_col     <= n_col;
                r_row     <= n_row;
                if (v_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Entry registers and output payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind   <= i_entry.kind;
            r_code   <= i_entry.code;
            r_digits <= i_entry.digits;
            r_left   <= i_entry.count;
            r_pre    <= (i_entry.kind == tcw_pkg::OP_HEX) ? 2'd2 : 2'd0;
        end else if (v_fire) begin
            if (r_pre != 2'd0) begin
                r_pre <= r_pre - 1'b1;
            end else begin
                r_digits <= {r_digits[tcw_pkg::DIG_W-5:0], 4'h0};
                r_left   <= r_left - 1'b1;
            end
            r_o_cell.addr <= v_addr[tcw_pkg::ADDR_W-1:0];
            r_o_cell.word <= {i_attr, v_char};
            r_o_cell.last <= v_last;
        end
    end

endmodule

// ----- rtl/text_console_cell_writer_unit.sv -----
// Top level of the text console cell writer.
// Instantiates tcw_front, tcw_fifo and tcw_back; depends on tcw_pkg.

// Each input transaction is a character, a 32-bit number printed in hex ("0x" and
// eight uppercase digits) or a 32-bit number printed in decimal (no leading zeros).
// Every printed character leaves as one output transaction carrying the cell address
// row*COLUMNS+column and the word {attribute, code}; tlast marks the final cell of an
// item, and a newline moves the cursor without any output. The back end loads each item
// from the queue and then emits one cell per cycle while the output is not stalled.
// A decimal number goes through the front's bit-serial BCD converter (one bit per
// cycle) and is then pushed into the queue; the front accepts no new transaction until
// that push, but this overlaps with the back end draining the previous item through
// the two-entry queue. The attribute register (reset 0x07) should be written only
// while idle.
module text_console_cell_writer_unit #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] char_code, [39:8] number
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [10:0] cell_address, [26:11] cell_word, rest zero
    output logic        m_axis_tlast    // last
);

    logic [7:0]      r_attr;
    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_empty;
    tcw_pkg::t_entry w_in_entry;
    tcw_pkg::t_entry w_out_entry;
    tcw_pkg::t_cell  w_cell;

    // Attribute register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_wr_en) begin
            r_attr <= i_cfg_wr_data;
        end
    end

    // Front: accepts and classifies transactions.
    tcw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_op     (s_axis_tuser),
        .i_code   (s_axis_tdata[7:0]),
        .i_number (s_axis_tdata[39:8]),
        .o_push   (w_push),
        .o_entry  (w_in_entry),
        .i_full   (w_full)
    );

    // Queue between front and back.
    tcw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_entry (w_out_entry)
    );

    // Back: cursor tracking and cell writes.
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_attr  (r_attr),
        .i_empty (w_empty),
        .i_entry (w_out_entry),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_cell  (w_cell)
    );

    assign m_axis_tdata = {5'b0, w_cell.word, w_cell.addr};
    assign m_axis_tlast = w_cell.last;

endmodule

// ----- rtl/tcw_checker.sv -----
// Port-level checker for the text console cell writer, bound to the top level.
// Depends on tcw_pkg for the newline code.
module tcw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled output transaction stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled output transaction keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // Reset empties the output stage.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A newline only moves the cursor and is never written to a cell.
    a_no_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[18:11] != tcw_pkg::NEWLINE_CODE))
        else $error("newline code written to a cell");

endmodule

bind text_console_cell_writer_unit tcw_checker u_tcw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
